// File: hdl/ofsd_pkg.sv
`timescale 1ns / 1ps

package ofsd_pkg;

    localparam int NSLOT      = 16;
    localparam int SLOT_W     = $clog2(NSLOT);
    localparam int RES_LIMIT  = 16;
    localparam int RES_W      = $clog2(RES_LIMIT + 1);
    localparam int LEN_W      = 24;
    localparam int FRAME_W    = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 24'd500;
    localparam logic [LEN_W-1:0] GAP_RESET = 24'd100;

    localparam logic       REG_LENGTH  = 1'b0;
    localparam logic       REG_SPACING = 1'b1;

    localparam logic [1:0] OP_FRAME  = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_FSCAN,
        ST_FPICK,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [FRAME_W-1:0] frame_number;
        logic               finish_ok;
    } in_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] slice_number;
        logic               forward;
        logic               complete;
        logic               ok_flag;
        logic               overflow;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic               step;
        logic               hit_any;
        logic               clr;
        logic [FRAME_W-1:0] tag;
        logic [LEN_W-1:0]   len;
    } cell_cmd_t;

    typedef struct packed {
        logic             hit;
        logic             free;
        logic [LEN_W-1:0] frames;
    } cell_chain_t;

endpackage

// File: hdl/ofsd_div.sv
`timescale 1ns / 1ps

module ofsd_div
    import ofsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [FRAME_W-1:0] dividend,
    input  logic [LEN_W-1:0]   divisor,
    output logic               busy,
    output logic [FRAME_W-1:0] quot,
    output logic [LEN_W-1:0]   rem
);

    localparam int CNT_W = $clog2(FRAME_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [FRAME_W-1:0] q_reg, q_next;
    logic [LEN_W-1:0]   r_reg, r_next;
    logic [LEN_W:0]     trial;

    always_comb
    begin
        trial    = {r_reg, q_reg[FRAME_W-1]};
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        if (start)
        begin
            cnt_next = CNT_W'(FRAME_W);
            q_next   = dividend;
            r_next   = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, divisor})
            begin
                r_next = LEN_W'(trial - {1'b0, divisor});
                q_next = {q_reg[FRAME_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[LEN_W-1:0];
                q_next = {q_reg[FRAME_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// File: hdl/ofsd_cell.sv
`timescale 1ns / 1ps

module ofsd_cell
    import ofsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_cmd_t          cmd,
    input  logic               kill,
    input  cell_chain_t        chain_in,
    output cell_chain_t        chain_out,
    output logic               valid,
    output logic [FRAME_W-1:0] tag
);

    logic               valid_reg, valid_next;
    logic [FRAME_W-1:0] tag_reg, tag_next;
    logic [LEN_W-1:0]   frames_reg, frames_next;
    logic               hit;
    logic               take;
    logic [LEN_W-1:0]   frames_inc;

    always_comb
    begin
        hit        = valid_reg && (tag_reg == cmd.tag);
        take       = !valid_reg && !chain_in.free && !cmd.hit_any;
        frames_inc = frames_reg + 1'b1;

        chain_out.hit    = chain_in.hit | hit;
        chain_out.free   = chain_in.free | !valid_reg;
        chain_out.frames = hit ? frames_reg : chain_in.frames;

        valid_next  = valid_reg;
        tag_next    = tag_reg;
        frames_next = frames_reg;
        if (cmd.clr)
        begin
            frames_next = '0;
        end
        if (kill)
        begin
            valid_next = 1'b0;
        end
        if (cmd.step)
        begin
            if (hit)
            begin
                frames_next = frames_inc;
                if (frames_inc == cmd.len)
                begin
                    valid_next = 1'b0;
                end
            end
            else if (take)
            begin
                tag_next    = cmd.tag;
                frames_next = LEN_W'(1);
                valid_next  = (cmd.len != LEN_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg    <= tag_next;
        frames_reg <= frames_next;
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;

endmodule

// File: hdl/overlapping_frame_slice_dispatcher.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_data (opcode, frame_number, finish_ok)
// out       out_valid / out_stall  out_data (slice_number .. last)
// cfg       cfg_we                 cfg_index, cfg_data
//
// Frame event: the two serial 32-step divides run side by side, then one
// covering slice per cycle through the slot chain while the output is not stalled.
// Finish: each closed slice takes a 16-slot tag scan plus a pick.
// Run start and unused opcodes are handled in the idle state. Reset empties all slots.
// A stalled output holds the sequencer once its one-entry holding stage fills.

module overlapping_frame_slice_dispatcher
    import ofsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [LEN_W-1:0] cfg_data
);

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_cfg_reg, gap_cfg_reg;
    logic [LEN_W-1:0]   len_eff, gap_eff;
    logic [FRAME_W:0]   i_reg, i_next;
    logic [FRAME_W-1:0] last_reg, last_next;
    logic [RES_W-1:0]   n_reg, n_next;
    logic               drop_reg, drop_next;
    logic               fin_reg, fin_next;
    logic               ok_reg, ok_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               found_reg, found_next;
    logic [FRAME_W-1:0] best_tag_reg, best_tag_next;
    logic [SLOT_W-1:0]  best_slot_reg, best_slot_next;
    out_item_t          pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               out_free;
    logic [FRAME_W-1:0] back;
    logic               div_start;
    logic               busy_a, busy_b;
    logic [FRAME_W-1:0] quot_a, quot_b;
    logic [LEN_W-1:0]   rem_a, rem_b;

    cell_cmd_t          cmd;
    cell_chain_t        chain [NSLOT+1];
    logic [NSLOT-1:0]   kill;
    logic [NSLOT-1:0]   slot_valid;
    logic [FRAME_W-1:0] slot_tag [NSLOT];
    logic               step_done;
    logic [FRAME_W-1:0] scan_tag;

    assign len_eff  = (len_cfg_reg == '0) ? LEN_W'(1) : len_cfg_reg;
    assign gap_eff  = (gap_cfg_reg == '0) ? LEN_W'(1) : gap_cfg_reg;
    assign back     = (in_data.frame_number >= FRAME_W'(len_eff))
                    ? in_data.frame_number - FRAME_W'(len_eff - 1'b1) : '0;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign scan_tag = slot_tag[idx_reg];

    ofsd_div u_div_first (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (back),
        .divisor  (gap_eff),
        .busy     (busy_a),
        .quot     (quot_a),
        .rem      (rem_a)
    );

    ofsd_div u_div_last (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_data.frame_number),
        .divisor  (gap_eff),
        .busy     (busy_b),
        .quot     (quot_b),
        .rem      (rem_b)
    );

    assign chain[0] = '{hit: 1'b0, free: 1'b0, frames: '0};

    for (genvar k = 0; k < NSLOT; k++)
    begin : g_cell
        ofsd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .kill      (kill[k]),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1]),
            .valid     (slot_valid[k]),
            .tag       (slot_tag[k])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        last_next       = last_reg;
        n_next          = n_reg;
        drop_next       = drop_reg;
        fin_next        = fin_reg;
        ok_next         = ok_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        best_tag_next   = best_tag_reg;
        best_slot_next  = best_slot_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        div_start       = 1'b0;
        kill            = '0;
        step_done       = 1'b0;

        cmd.step    = 1'b0;
        cmd.hit_any = chain[NSLOT].hit;
        cmd.clr     = 1'b0;
        cmd.tag     = i_reg[FRAME_W-1:0];
        cmd.len     = len_eff;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next    = '0;
                    drop_next = 1'b0;
                    ok_next   = in_data.finish_ok;
                    unique case (in_data.opcode)
                        OP_FRAME:
                        begin
                            div_start  = 1'b1;
                            fin_next   = 1'b0;
                            state_next = ST_DIV;
                        end
                        OP_START:
                        begin
                            cmd.clr = 1'b1;
                        end
                        OP_FINISH:
                        begin
                            fin_next   = 1'b1;
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = ST_FSCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (!busy_a && !busy_b)
                begin
                    i_next     = {1'b0, quot_a} + ((rem_a != '0) ? 1'b1 : 1'b0);
                    last_next  = quot_b;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (i_reg > {1'b0, last_reg})
                begin
                    state_next = ST_FINAL;
                end
                else if (n_reg == RES_W'(RES_LIMIT))
                begin
                    drop_next  = 1'b1;
                    state_next = ST_FINAL;
                end
                else if (!chain[NSLOT].hit && !chain[NSLOT].free)
                begin
                    drop_next  = 1'b1;
                    state_next = ST_FINAL;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    cmd.step = 1'b1;
                    if (chain[NSLOT].hit)
                    begin
                        step_done = (LEN_W'(chain[NSLOT].frames + 1'b1) == len_eff);
                    end
                    else
                    begin
                        step_done = (len_eff == LEN_W'(1));
                    end
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_next       = '{slice_number: i_reg[FRAME_W-1:0], forward: 1'b1,
                                        complete: step_done, ok_flag: step_done,
                                        overflow: 1'b0, last: 1'b0};
                    pend_valid_next = 1'b1;
                    n_next          = n_reg + 1'b1;
                    i_next          = i_reg + 1'b1;
                end
            end
            ST_FSCAN:
            begin
                if (slot_valid[idx_reg] && (!found_reg || scan_tag < best_tag_reg))
                begin
                    found_next     = 1'b1;
                    best_tag_next  = scan_tag;
                    best_slot_next = idx_reg;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_W'(NSLOT - 1))
                begin
                    state_next = ST_FPICK;
                end
            end
            ST_FPICK:
            begin
                if (!found_reg)
                begin
                    state_next = ST_FINAL;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    kill[best_slot_reg] = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_next       = '{slice_number: best_tag_reg, forward: 1'b0,
                                        complete: 1'b1, ok_flag: ok_reg,
                                        overflow: 1'b0, last: 1'b0};
                    pend_valid_next = 1'b1;
                    n_next          = n_reg + 1'b1;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    if (n_reg == RES_W'(RES_LIMIT - 1))
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = ST_FSCAN;
                    end
                end
            end
            ST_FINAL:
            begin
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_next          = pend_reg;
                        out_next.last     = 1'b1;
                        out_next.overflow = fin_reg ? (|slot_valid) : drop_reg;
                        out_valid_next    = 1'b1;
                        pend_valid_next   = 1'b0;
                        state_next        = ST_IDLE;
                    end
                end
                else if (drop_reg && !fin_reg)
                begin
                    if (out_free)
                    begin
                        out_next       = '{slice_number: i_reg[FRAME_W-1:0], forward: 1'b0,
                                           complete: 1'b0, ok_flag: 1'b0,
                                           overflow: 1'b1, last: 1'b1};
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_cfg_reg    <= LEN_RESET;
            gap_cfg_reg    <= GAP_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_LENGTH)
                begin
                    len_cfg_reg <= cfg_data;
                end
                if (cfg_index == REG_SPACING)
                begin
                    gap_cfg_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        last_reg      <= last_next;
        n_reg         <= n_next;
        drop_reg      <= drop_next;
        fin_reg       <= fin_next;
        ok_reg        <= ok_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        best_tag_reg  <= best_tag_next;
        best_slot_reg <= best_slot_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: tb/tb_overlapping_frame_slice_dispatcher.sv
`timescale 1ns / 1ps

module tb_overlapping_frame_slice_dispatcher;
    import ofsd_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;
    logic             cfg_we;
    logic             cfg_index;
    logic [LEN_W-1:0] cfg_data;

    overlapping_frame_slice_dispatcher u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [LEN_W-1:0]   len_q;
    logic [LEN_W-1:0]   gap_q;
    logic [FRAME_W-1:0] slot_tag [NSLOT];
    logic [LEN_W-1:0]   slot_cnt [NSLOT];
    logic               slot_used [NSLOT];

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int        mismatches;
    int        sent_count;
    bit        calm;
    bit        hold_req;
    bit        holding;
    int        in_gap;
    int        out_gap;

    function automatic out_item_t mk(logic [FRAME_W-1:0] sn, logic fw, logic cp, logic ok);
        out_item_t r;
        r.slice_number = sn;
        r.forward = fw;
        r.complete = cp;
        r.ok_flag = ok;
        r.overflow = 1'b0;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic dispatch_item(input in_item_t it);
        out_item_t res [$];
        longint unsigned len, gap, f, back, first, lastk, i;
        bit dropped;
        int s, fs, best;
        bit done;
        dropped = 0;
        if (it.opcode == OP_FRAME) begin
            len = (len_q == 0) ? 1 : len_q;
            gap = (gap_q == 0) ? 1 : gap_q;
            f = it.frame_number;
            back = (f >= len) ? f - (len - 1) : 0;
            first = back / gap + ((back % gap) ? 1 : 0);
            lastk = f / gap;
            i = first;
            while (i <= lastk) begin
                if (res.size() == RES_LIMIT) begin
                    dropped = 1;
                    break;
                end
                s = -1;
                for (int k = 0; k < NSLOT; k++)
                    if (s < 0 && slot_used[k] && slot_tag[k] == i[31:0]) s = k;
                if (s < 0) begin
                    fs = -1;
                    for (int k = 0; k < NSLOT; k++)
                        if (fs < 0 && !slot_used[k]) fs = k;
                    if (fs < 0) begin
                        dropped = 1;
                        break;
                    end
                    s = fs;
                    slot_used[s] = 1;
                    slot_tag[s] = i[31:0];
                    slot_cnt[s] = '0;
                end
                slot_cnt[s] = slot_cnt[s] + 1'b1;
                done = (longint'(slot_cnt[s]) == len);
                if (done) slot_used[s] = 0;
                res = {res, mk(i[31:0], 1'b1, done, done)};
                i++;
            end
            if (dropped) begin
                if (res.size() == 0) res = {res, mk(i[31:0], 1'b0, 1'b0, 1'b0)};
                res[res.size()-1].overflow = 1'b1;
            end
        end else if (it.opcode == OP_START) begin
            for (int k = 0; k < NSLOT; k++) slot_cnt[k] = '0;
        end else if (it.opcode == OP_FINISH) begin
            while (res.size() < RES_LIMIT) begin
                best = -1;
                for (int k = 0; k < NSLOT; k++)
                    if (slot_used[k] && (best < 0 || slot_tag[k] < slot_tag[best])) best = k;
                if (best < 0) break;
                res = {res, mk(slot_tag[best], 1'b0, 1'b1, it.finish_ok)};
                slot_used[best] = 0;
            end
            if (res.size() > 0)
                for (int k = 0; k < NSLOT; k++)
                    if (slot_used[k]) res[res.size()-1].overflow = 1'b1;
        end
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[k]) expected_results = {expected_results, res[k]};
    endtask

    function automatic in_item_t mk_in(logic [1:0] op, logic [31:0] fr, logic ok);
        in_item_t it;
        it.opcode = op;
        it.frame_number = fr;
        it.finish_ok = ok;
        return it;
    endfunction

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                dispatch_item(in_data);
                sent_count++;
            end
            if (in_valid && in_stall) begin
            end else if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (!calm && !holding && $urandom_range(0, 5) == 0) begin
                in_gap = $urandom_range(1, 3) - 1;
                in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    initial begin
        wait (hold_req);
        holding = 1;
        repeat (600) @(posedge clk);
        holding = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction %p", out_data);
                end else begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (e !== out_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", e, out_data);
                    end
                end
            end
            if (holding) begin
                out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(1, 3) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_drain();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [LEN_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LENGTH) len_q = v;
        else gap_q = v;
    endtask

    task automatic add_item(input in_item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic random_phase(input int n, input int span);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0) add_item(mk_in(OP_START, $urandom, 1'($urandom)));
            else if (r == 1) add_item(mk_in(OP_FINISH, $urandom, 1'($urandom)));
            else if (r == 2) add_item(mk_in(OP_FRAME, $urandom, 1'($urandom)));
            else add_item(mk_in(OP_FRAME, $urandom_range(0, span), 1'($urandom)));
        end
    endtask

    initial begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_LENGTH;
        cfg_data = '0;
        calm = 0;
        hold_req = 0;
        mismatches = 0;
        sent_count = 0;
        len_q = LEN_RESET;
        gap_q = GAP_RESET;
        for (int k = 0; k < NSLOT; k++) slot_used[k] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        add_item(mk_in(OP_FRAME, 32'd0, 1'b0));
        add_item(mk_in(OP_FRAME, 32'd450, 1'b1));
        add_item(mk_in(OP_FRAME, 32'hFFFF_FFFF, 1'b0));
        add_item(mk_in(OP_START, 32'hFFFF_FFFF, 1'b1));
        add_item(mk_in(OP_UNUSED, 32'h5555_AAAA, 1'b1));
        add_item(mk_in(OP_FINISH, 32'd0, 1'b1));
        wait_drain();

        write_reg(REG_LENGTH, 24'd40);
        write_reg(REG_SPACING, 24'd2);
        add_item(mk_in(OP_FRAME, 32'd100, 1'b0));
        add_item(mk_in(OP_FRAME, 32'd200, 1'b0));
        add_item(mk_in(OP_FINISH, 32'd0, 1'b0));
        add_item(mk_in(OP_FINISH, 32'd0, 1'b1));
        wait_drain();

        write_reg(REG_LENGTH, 24'd3);
        write_reg(REG_SPACING, 24'd5);
        add_item(mk_in(OP_FRAME, 32'd3, 1'b0));
        for (int k = 0; k < 3; k++) add_item(mk_in(OP_FRAME, 32'd7, 1'b0));
        add_item(mk_in(OP_FRAME, 32'd11, 1'b0));
        add_item(mk_in(OP_START, 32'd0, 1'b0));
        add_item(mk_in(OP_FRAME, 32'd11, 1'b0));
        add_item(mk_in(OP_FINISH, 32'd0, 1'b1));
        wait_drain();

        write_reg(REG_LENGTH, 24'd0);
        write_reg(REG_SPACING, 24'd0);
        add_item(mk_in(OP_FRAME, 32'd9, 1'b0));
        wait_drain();
        write_reg(REG_LENGTH, 24'hFFFFFF);
        write_reg(REG_SPACING, 24'hFFFFFF);
        add_item(mk_in(OP_FRAME, 32'hFFFF_FFFF, 1'b0));
        add_item(mk_in(OP_FRAME, 32'h00FF_FFFE, 1'b0));
        add_item(mk_in(OP_FINISH, 32'd0, 1'b0));
        wait_drain();

        write_reg(REG_LENGTH, 24'd4);
        write_reg(REG_SPACING, 24'd1);
        hold_req = 1;
        random_phase(70, 60);
        wait_drain();

        write_reg(REG_LENGTH, 24'd20);
        write_reg(REG_SPACING, 24'd3);
        random_phase(70, 200);
        wait_drain();

        write_reg(REG_LENGTH, 24'd7);
        write_reg(REG_SPACING, 24'd4);
        random_phase(70, 120);
        wait_drain();

        calm = 1;
        write_reg(REG_LENGTH, 24'd9);
        write_reg(REG_SPACING, 24'd2);
        random_phase(40, 80);
        wait_drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("overlapping_frame_slice_dispatcher regression: pass");
        else
            $display("overlapping_frame_slice_dispatcher regression: fail");
        $finish;
    end

    initial begin
        #4000000;
        $display("overlapping_frame_slice_dispatcher regression: fail");
        $finish;
    end

endmodule
